// ----- hw/rtl/wstf_pkg.sv -----
// Package for the wave sample converter: widths, codes, register indexes and shared types.
`default_nettype none

package wstf_pkg;

   localparam int RAW_W       = 32;
   localparam int VALUE_W     = 48;
   localparam int FORMAT_W    = 2;
   localparam int BITS_W      = 6;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   // format_kind codes
   localparam logic [FORMAT_W-1:0] FMT_PCM   = 2'd0;
   localparam logic [FORMAT_W-1:0] FMT_FLOAT = 2'd1;

   // supported PCM widths
   localparam logic [BITS_W-1:0] PCM_BITS_8  = 6'd8;
   localparam logic [BITS_W-1:0] PCM_BITS_16 = 6'd16;
   localparam logic [BITS_W-1:0] PCM_BITS_24 = 6'd24;
   localparam logic [BITS_W-1:0] PCM_BITS_32 = 6'd32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT_KIND = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_BITS = 8'd1;

   localparam logic [FORMAT_W-1:0] FORMAT_KIND_RESET = FMT_PCM;
   localparam logic [BITS_W-1:0]   SAMPLE_BITS_RESET = PCM_BITS_16;

   // float exponent thresholds: shift = exponent - FLT_SHIFT_BIAS
   localparam logic [7:0] FLT_EXP_SPECIAL = 8'hFF;
   localparam logic [7:0] FLT_SHIFT_BIAS  = 8'd119;
   localparam logic [7:0] FLT_EXP_OVER    = 8'd143;
   localparam logic [6:0] FLT_RSH_ZERO    = 7'd24;

   localparam logic [VALUE_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

   typedef struct packed {
      logic [FORMAT_W-1:0] format_kind;
      logic [BITS_W-1:0]   sample_bits;
   } cfg_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sample_value;
      logic                      saturated;
      logic                      supported;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/wstf_if.sv -----
// Channel interfaces: request, result and register write.
`default_nettype none

interface wstf_req_if
   import wstf_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);
endinterface

interface wstf_rsp_if
   import wstf_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] sample_value;
   logic                      saturated;
   logic                      supported;

   modport source (output valid, output sample_value, output saturated, output supported,
                   input ready);
   modport sink   (input valid, input sample_value, input saturated, input supported,
                   output ready);
endinterface

interface wstf_csr_if
   import wstf_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wstf_csr.sv -----
// Configuration registers: format kind and PCM sample width.
`default_nettype none

module wstf_csr
   import wstf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   wstf_csr_if.sink csr_chan,
   output cfg_type  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_FORMAT_KIND: cfg_in.format_kind = csr_chan.data[FORMAT_W-1:0];
            CSR_SAMPLE_BITS: cfg_in.sample_bits = csr_chan.data[BITS_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format_kind <= FORMAT_KIND_RESET;
         cfg_ff.sample_bits <= SAMPLE_BITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/wstf_convert.sv -----
// Single-pass conversion of one raw sample to 48-bit fixed point.
`default_nettype none

module wstf_convert
   import wstf_pkg::*;
(
   input  cfg_type          cfg,
   input  logic [RAW_W-1:0] raw_sample,
   output result_type       result
);

   logic                 sign;
   logic [7:0]           expo;
   logic [22:0]          man;
   logic [23:0]          mant;
   logic [7:0]           expo_eff;
   logic [4:0]           lsh;
   logic [6:0]           rsh;
   logic                 over;
   logic [VALUE_W-1:0]   mag;
   logic                 clip;
   logic [VALUE_W-1:0]   flt_value;
   logic                 flt_sat;
   logic [VALUE_W-1:0]   pcm_value;
   logic                 pcm_ok;

   // float path
   always_comb begin
      sign     = raw_sample[31];
      expo     = raw_sample[30:23];
      man      = raw_sample[22:0];
      mant     = {(expo != 8'd0), man};
      expo_eff = (expo != 8'd0) ? expo : 8'd1;   // denormals use exponent one
      over     = expo_eff > FLT_EXP_OVER;
      lsh      = 5'(expo_eff - FLT_SHIFT_BIAS);
      rsh      = 7'(FLT_SHIFT_BIAS - expo_eff);
      mag      = '0;
      if (expo_eff >= FLT_SHIFT_BIAS) begin
         mag = {24'd0, mant} << lsh;
      end else if (rsh < FLT_RSH_ZERO) begin
         mag = {24'd0, mant >> rsh[4:0]};
      end

      // -2^47 itself is exact and not clipped
      if (sign) begin
         clip = over || (mag[VALUE_W-1] && (mag[VALUE_W-2:0] != '0));
      end else begin
         clip = over || mag[VALUE_W-1];
      end

      flt_sat   = 1'b0;
      flt_value = '0;
      if (expo == FLT_EXP_SPECIAL) begin
         if (man == 23'd0) begin
            flt_sat   = 1'b1;
            flt_value = sign ? NEG_LIMIT : POS_LIMIT;
         end
      end else if (clip) begin
         flt_sat   = 1'b1;
         flt_value = sign ? NEG_LIMIT : POS_LIMIT;
      end else begin
         flt_value = sign ? (~mag + 1'b1) : mag;
      end
   end

   // PCM path
   always_comb begin
      pcm_ok    = 1'b1;
      pcm_value = '0;
      unique case (cfg.sample_bits)
         PCM_BITS_8:  pcm_value = {{16{~raw_sample[7]}}, ~raw_sample[7], raw_sample[6:0], 24'd0};
         PCM_BITS_16: pcm_value = {{16{raw_sample[15]}}, raw_sample[15:0], 16'd0};
         PCM_BITS_24: pcm_value = {{16{raw_sample[23]}}, raw_sample[23:0], 8'd0};
         PCM_BITS_32: pcm_value = {{16{raw_sample[31]}}, raw_sample};
         default:     pcm_ok    = 1'b0;
      endcase
   end

   always_comb begin
      result = '0;
      unique case (cfg.format_kind)
         FMT_FLOAT: begin
            result.sample_value = flt_value;
            result.saturated    = flt_sat;
            result.supported    = 1'b1;
         end
         FMT_PCM: begin
            result.sample_value = pcm_ok ? pcm_value : '0;
            result.supported    = pcm_ok;
         end
         default: result = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/wave_sample_to_fixed_converter_unit.sv -----
// Wave sample converter top level: input register, converter and result register.
// Takes one raw little-endian sample per cycle unless stalled and returns it as signed
// 48-bit fixed point with 16 fraction bits on a 16-bit full scale (PCM 8/16/24/32 bit or
// IEEE single float). Throughput is one request per cycle while results are taken: a request
// is captured in the input register, converted in one pass, and held in the result register
// until taken. While a result waits, only an empty input register takes a new request.
// Registers: index 0 format_kind, index 1 sample_bits; write them only while idle.
`default_nettype none

module wave_sample_to_fixed_converter_unit
   import wstf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wstf_req_if.sink   req_chan,
   wstf_rsp_if.source rsp_chan,
   wstf_csr_if.sink   csr_chan
);

   cfg_type          cfg;
   result_type       conv_result;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [RAW_W-1:0] s1_raw_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   result_type       rsp_data_ff;
   logic             s1_ready;
   logic             s2_ready;

   wstf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   wstf_convert u_convert (
      .cfg        (cfg),
      .raw_sample (s1_raw_ff),
      .result     (conv_result)
   );

   assign s2_ready       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;

   always_comb begin
      s1_valid_in  = s1_ready ? req_chan.valid : s1_valid_ff;
      rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_chan.valid) begin
         s1_raw_ff <= req_chan.raw_sample;
      end
      if (s2_ready && s1_valid_ff) begin
         rsp_data_ff <= conv_result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample_value = rsp_data_ff.sample_value;
   assign rsp_chan.saturated    = rsp_data_ff.saturated;
   assign rsp_chan.supported    = rsp_data_ff.supported;

`ifndef ASSERT_OFF
   // unsupported results are always zero and never flagged
   a_unsup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.supported |->
         rsp_data_ff.sample_value == '0 && !rsp_data_ff.saturated)
      else $error("unsupported result not zero");

   // only the float path can clip
   a_sat_float: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.saturated |->
         rsp_data_ff.supported && cfg.format_kind == FMT_FLOAT)
      else $error("saturation outside float format");

   // a stalled input register keeps its request
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_raw_ff))
      else $error("input register lost a stalled request");

   // back-pressure reaches the input only when the input register is full
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("request refused with free space");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/wstf_result_checker.sv -----
// Checker for the wave sample converter: watches all channels, predicts results, compares.
module wstf_result_checker
   import wstf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [RAW_W-1:0]          req_raw_sample,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [VALUE_W-1:0] rsp_sample_value,
   input  logic                      rsp_saturated,
   input  logic                      rsp_supported,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   output int                        mismatch_count,
   output int                        pending_count,
   output int                        results_checked,
   output int                        clipped_seen,
   output int                        unsupported_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // single float: value * 2^31 = mantissa * 2^(exponent - 127 - 23 + 31)
   localparam int          FLOAT_SHIFT_BIAS = 127 + 23 - 31;
   localparam int          FLOAT_SHIFT_MAX  = 24;
   localparam logic [7:0]  FLOAT_EXP_ALL1   = 8'hFF;
   localparam logic [63:0] MAG_POS_MAX      = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] MAG_NEG_MAX      = 64'h0000_8000_0000_0000;

   cfg_type    cfg_shadow;
   result_type expected_q[$];

   function automatic result_type convert_sample(input cfg_type cfg,
                                                 input logic [RAW_W-1:0] raw);
      result_type  r;
      logic [23:0] mant;
      logic [63:0] mag;
      int          expo;
      int          shift;
      r = '0;
      r.supported = 1'b1;
      if (cfg.format_kind == FMT_FLOAT) begin
         if (raw[30:23] == FLOAT_EXP_ALL1) begin
            // infinities clip, NaN stays at zero
            if (raw[22:0] == '0) begin
               r.saturated    = 1'b1;
               r.sample_value = raw[31] ? MAG_NEG_MAX[VALUE_W-1:0] : MAG_POS_MAX[VALUE_W-1:0];
            end
         end else begin
            mant  = {(raw[30:23] != 8'd0), raw[22:0]};
            expo  = (raw[30:23] != 8'd0) ? int'(raw[30:23]) : 1;
            shift = expo - FLOAT_SHIFT_BIAS;
            if (shift > FLOAT_SHIFT_MAX)
               mag = MAG_NEG_MAX + 64'd1;
            else if (shift >= 0)
               mag = 64'(mant) << shift;
            else
               mag = 64'(mant) >> (-shift);
            if (raw[31]) begin
               if (mag > MAG_NEG_MAX) begin
                  r.saturated = 1'b1;
                  mag = MAG_NEG_MAX;
               end
               mag = ~mag + 64'd1;
            end else if (mag > MAG_POS_MAX) begin
               r.saturated = 1'b1;
               mag = MAG_POS_MAX;
            end
            r.sample_value = mag[VALUE_W-1:0];
         end
      end else if (cfg.format_kind == FMT_PCM) begin
         case (cfg.sample_bits)
            // 8-bit is offset binary: flipping the top bit removes the 128 offset
            PCM_BITS_8:  r.sample_value = {{16{~raw[7]}}, ~raw[7], raw[6:0], 24'd0};
            PCM_BITS_16: r.sample_value = {{16{raw[15]}}, raw[15:0], 16'd0};
            PCM_BITS_24: r.sample_value = {{16{raw[23]}}, raw[23:0], 8'd0};
            PCM_BITS_32: r.sample_value = {{16{raw[31]}}, raw[31:0]};
            default:     r.supported = 1'b0;
         endcase
      end else begin
         r.supported = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t ns mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg_shadow       <= '{format_kind: FORMAT_KIND_RESET, sample_bits: SAMPLE_BITS_RESET};
         expected_q.delete();
         mismatch_count   = 0;
         results_checked  = 0;
         clipped_seen     = 0;
         unsupported_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FORMAT_KIND)
               cfg_shadow.format_kind <= csr_data[FORMAT_W-1:0];
            else if (csr_index == CSR_SAMPLE_BITS)
               cfg_shadow.sample_bits <= csr_data[BITS_W-1:0];
         end
         if (req_valid && req_ready)
            expected_q.push_back(convert_sample(cfg_shadow, req_raw_sample));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = expected_q.pop_front();
               results_checked++;
               if (want.saturated)
                  clipped_seen++;
               if (!want.supported)
                  unsupported_seen++;
               if (rsp_sample_value !== want.sample_value)
                  report_mismatch($sformatf("sample_value %h, expected %h",
                                            rsp_sample_value, want.sample_value));
               if (rsp_saturated !== want.saturated)
                  report_mismatch($sformatf("saturated %b, expected %b",
                                            rsp_saturated, want.saturated));
               if (rsp_supported !== want.supported)
                  report_mismatch($sformatf("supported %b, expected %b",
                                            rsp_supported, want.supported));
            end
         end
      end
      pending_count = expected_q.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the wave sample converter: clock, reset, stimulus, receiver and verdict.
module tb_top
   import wstf_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FORMAT_W-1:0] FMT_RESERVED_2   = 2'd2;
   localparam logic [FORMAT_W-1:0] FMT_RESERVED_3   = 2'd3;
   localparam int                  LONG_HOLD_CYCLES = 200;
   localparam int                  DRAIN_CYCLES     = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wstf_req_if req_chan ();
   wstf_rsp_if rsp_chan ();
   wstf_csr_if csr_chan ();

   int mismatch_count;
   int pending_count;
   int results_checked;
   int clipped_seen;
   int unsupported_seen;

   int requests_sent    = 0;
   int settings_applied = 0;
   bit sender_steady    = 1'b0;
   bit receiver_steady  = 1'b0;
   bit long_hold_due    = 1'b0;

   logic [CSR_DATA_W-1:0] applied_format = CSR_DATA_W'(FORMAT_KIND_RESET);
   logic [CSR_DATA_W-1:0] applied_bits   = CSR_DATA_W'(SAMPLE_BITS_RESET);

   wave_sample_to_fixed_converter_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   wstf_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_raw_sample   (req_chan.raw_sample),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_sample_value (rsp_chan.sample_value),
      .rsp_saturated    (rsp_chan.saturated),
      .rsp_supported    (rsp_chan.supported),
      .csr_valid        (csr_chan.valid),
      .csr_ready        (csr_chan.ready),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .results_checked  (results_checked),
      .clipped_seen     (clipped_seen),
      .unsupported_seen (unsupported_seen)
   );

   always #5ns clock = ~clock;

   initial begin
      #3ms;
      $display("timeout with %0d results outstanding", pending_count);
      $display("status: fail");
      $finish;
   end

   // called at a falling edge; leaves valid high after the request is taken
   task automatic send_sample(input logic [RAW_W-1:0] raw);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.raw_sample <= raw;
      do @(posedge clock); while (!req_chan.ready);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
   endtask

   // drain the pipe, poke a register that does not exist, then set both real ones
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] format_data,
                                input logic [CSR_DATA_W-1:0] bits_data);
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      write_reg(CSR_INDEX_W'($urandom_range(2, 255)), CSR_DATA_W'($urandom));
      write_reg(CSR_FORMAT_KIND, format_data);
      write_reg(CSR_SAMPLE_BITS, bits_data);
      csr_chan.valid <= 1'b0;
      applied_format = format_data;
      applied_bits   = bits_data;
      settings_applied++;
   endtask

   task automatic directed_sample(input logic [CSR_DATA_W-1:0] format_data,
                                  input logic [CSR_DATA_W-1:0] bits_data,
                                  input logic [RAW_W-1:0] raw);
      if (format_data != applied_format || bits_data != applied_bits)
         apply_setting(format_data, bits_data);
      send_sample(raw);
   endtask

   function automatic logic [RAW_W-1:0] random_raw();
      logic [RAW_W-1:0] raw;
      int               w;
      bit               b;
      raw = $urandom;
      case ($urandom_range(0, 7))
         3: raw[30:23] = 8'($urandom_range(100, 150));   // float around the fixed range
         4: raw[30:23] = 8'd0;                           // zero and denormals
         5: begin                                        // infinities and NaN
            raw[30:23] = 8'hFF;
            if ($urandom_range(0, 1))
               raw[22:0] = '0;
         end
         6: begin                                        // PCM extremes, upper bytes kept random
            w = 8 * $urandom_range(1, 4);
            b = 1'($urandom_range(0, 1));
            for (int i = 0; i < w; i++)
               raw[i] = (i == w - 1) ? b : ~b;
         end
         7: begin                                        // float clip boundary
            raw[30:23] = 8'($urandom_range(142, 144));
            if ($urandom_range(0, 1))
               raw[22:0] = '0;
         end
         default: ;
      endcase
      return raw;
   endfunction

   task automatic run_phase(input logic [CSR_DATA_W-1:0] format_data,
                            input logic [CSR_DATA_W-1:0] bits_data,
                            input int count, input bit hold_off);
      apply_setting(format_data, bits_data);
      // back-to-back requests while the receiver holds off, so the pipe backs up
      sender_steady = hold_off || ($urandom_range(0, 3) == 0);
      if (hold_off)
         long_hold_due = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (n == count / 3)
            sender_steady = ($urandom_range(0, 3) == 0);
         send_sample(random_raw());
      end
   endtask

   // receiver: random back-pressure with the odd long hold
   initial begin
      int gap;
      int taken;
      taken = 0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            if (taken % 48 == 0)
               receiver_steady = ($urandom_range(0, 2) == 0);
            gap = receiver_steady ? 0 : $urandom_range(0, 11);
            if (gap != 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.raw_sample = '0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = '0;
      csr_chan.data       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset setting first: 16-bit PCM, upper bytes ignored
      directed_sample(CSR_DATA_W'(FMT_PCM), CSR_DATA_W'(PCM_BITS_16), 32'h0000_8000);
      directed_sample(CSR_DATA_W'(FMT_PCM), CSR_DATA_W'(PCM_BITS_16), 32'hFFFF_7FFF);
      directed_sample(CSR_DATA_W'(FMT_PCM), CSR_DATA_W'(PCM_BITS_8),  32'h0000_0000);
      directed_sample(CSR_DATA_W'(FMT_PCM), CSR_DATA_W'(PCM_BITS_8),  32'hFFFF_FFFF);
      directed_sample(CSR_DATA_W'(FMT_PCM), CSR_DATA_W'(PCM_BITS_24), 32'h0080_0000);
      directed_sample(CSR_DATA_W'(FMT_PCM), CSR_DATA_W'(PCM_BITS_24), 32'hFF7F_FFFF);
      directed_sample(CSR_DATA_W'(FMT_PCM), CSR_DATA_W'(PCM_BITS_32), 32'h8000_0000);
      directed_sample(CSR_DATA_W'(FMT_PCM), CSR_DATA_W'(PCM_BITS_32), 32'h7FFF_FFFF);
      // float ignores the width register
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'h0000_0000);
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'h8000_0000);  // negative zero
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'h7F80_0000);  // +inf
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'hFF80_0000);  // -inf
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'h7FC0_0001);  // NaN
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'h0000_0001);  // smallest denormal
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'h3F80_0000);  // 1.0
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'hBFC0_0000);  // -1.5
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'h4780_0000);  // +2^16 clips
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'hC780_0000);  // -2^16 exact
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'hC780_0001);  // just past negative limit
      directed_sample(CSR_DATA_W'(FMT_FLOAT), 8'd0, 32'h4F00_0000);  // far out of range
      directed_sample(CSR_DATA_W'(FMT_RESERVED_2), CSR_DATA_W'(PCM_BITS_16), 32'h1234_5678);
      directed_sample(8'hFF, CSR_DATA_W'(PCM_BITS_16), 32'hFFFF_FFFF);  // masks to format 3
      directed_sample(CSR_DATA_W'(FMT_PCM), 8'd0,  32'hFFFF_FFFF);
      directed_sample(CSR_DATA_W'(FMT_PCM), 8'hFF, 32'h0000_8000);      // masks to width 63
      directed_sample(CSR_DATA_W'(FMT_PCM), 8'd12, 32'h0000_0FFF);

      run_phase(CSR_DATA_W'(FMT_PCM),   CSR_DATA_W'(PCM_BITS_8),  150, 1'b0);
      run_phase(CSR_DATA_W'(FMT_PCM),   CSR_DATA_W'(PCM_BITS_16), 150, 1'b0);
      run_phase(CSR_DATA_W'(FMT_PCM),   CSR_DATA_W'(PCM_BITS_24), 150, 1'b0);
      run_phase(CSR_DATA_W'(FMT_PCM),   CSR_DATA_W'(PCM_BITS_32), 200, 1'b1);
      run_phase(CSR_DATA_W'(FMT_FLOAT), CSR_DATA_W'(PCM_BITS_32), 250, 1'b0);
      run_phase(8'hFD, 8'hFF, 250, 1'b1);   // masks to float, width 63
      run_phase(8'hFC, 8'hD8, 100, 1'b0);   // masks to PCM, width 24
      run_phase(CSR_DATA_W'(FMT_RESERVED_2), CSR_DATA_W'(PCM_BITS_8),  40, 1'b0);
      run_phase(CSR_DATA_W'(FMT_RESERVED_3), CSR_DATA_W'(PCM_BITS_32), 40, 1'b0);
      run_phase(CSR_DATA_W'(FMT_PCM), 8'd0,  40, 1'b0);
      run_phase(CSR_DATA_W'(FMT_PCM), 8'h3F, 40, 1'b0);
      run_phase(CSR_DATA_W'(FMT_PCM), 8'd31, 40, 1'b0);
      run_phase(CSR_DATA_W'(FMT_PCM), CSR_DATA_W'(PCM_BITS_8), 50, 1'b0);

      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d requests over %0d register settings, %0d results checked",
               requests_sent, settings_applied, results_checked);
      $display("of those %0d clipped floats and %0d unsupported settings, %0d mismatches",
               clipped_seen, unsupported_seen, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
